### design/table_linear_interpolator_core_macros.svh
// Assertion helpers for the interpolator core
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication, reset-gated
`define TLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tli assertion failed");

// next-cycle implication, reset-gated
`define TLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tli assertion failed");

`endif

### design/tli_pkg.sv
package tli_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int   DW       = 32;
    localparam int   CNT_W    = 11;
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_HIT,
        S_LO,
        S_HI,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

endpackage

### design/table_linear_interpolator_core.sv
// A query whose walk pointer already sits at or past the last point is answered from idle;
// else the walk reads table x values one by one, then an exact hit returns that point's y,
// a degenerate bracket returns the lower y after its two reads, and an interpolation does
// two reads, one 32x32 multiply, 32 restoring divide steps and a final add or subtract.
// Loads never raise busy. Results are strobed for one cycle; the receiver cannot stall.
// Synchronous reset clears the walk pointer and sets table_count to 2; memories unchanged.
`include "table_linear_interpolator_core_macros.svh"

module table_linear_interpolator_core
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_opcode,
    input  logic [9:0]       i_point_index,
    input  logic [DW-1:0]    i_x_value,
    input  logic [DW-1:0]    i_y_value,
    input  logic             i_last_of_run,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [DW-1:0]    o_y_out,
    output logic             o_in_range
);

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

    logic [DW-1:0] mem_x [TABLE_DEPTH];
    logic [DW-1:0] mem_y [TABLE_DEPTH];

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_j, n_j;
    logic [DW-1:0]    r_x, n_x;
    logic             r_last, n_last;
    logic [DW-1:0]    r_rx, r_ry;
    logic [DW-1:0]    r_x1, n_x1;
    logic [DW-1:0]    r_x0, n_x0;
    logic [DW-1:0]    r_y0, n_y0;
    logic             r_neg, n_neg;
    logic [DW-1:0]    r_mag, n_mag;
    logic [DW-1:0]    r_dx, n_dx;
    logic [DW-1:0]    r_d, n_d;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_lo, n_lo;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic [DW-1:0]    r_y_out, n_y_out;
    logic             r_in_range, n_in_range;

    logic [NW-1:0]    cnt_ext, n_eff;
    logic [AW-1:0]    n1;
    logic             ld_acc;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             q_acc;
    logic             walk_more, hit_eq, interior, degen;
    logic [DW:0]      dy;
    logic [2*DW-1:0]  prod;
    logic [DW:0]      trial;
    logic             ge;

    assign cnt_ext = NW'(r_count);
    assign n_eff   = (cnt_ext < NW'(2)) ? NW'(2) :
                     (cnt_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : cnt_ext;
    assign n1      = AW'(n_eff - NW'(1));

    assign q_acc   = start && (r_state == S_IDLE) && (i_opcode == OP_QUERY);
    assign ld_acc  = start && (r_state == S_IDLE) && (i_opcode == OP_LOAD);
    assign mem_we  = ld_acc && (32'(i_point_index) < 32'(TABLE_DEPTH));
    assign wr_addr = AW'(i_point_index);

    assign walk_more = (r_j < n1) && ($signed(r_x) > $signed(r_rx));
    assign hit_eq    = (r_x == r_rx);
    assign interior  = (r_j < n1) && (r_j != '0);
    assign degen     = ($signed(r_x1) <= $signed(r_x0)) || ($signed(r_x) <= $signed(r_x0));
    assign dy        = {r_ry[DW-1], r_ry} - {r_y0[DW-1], r_y0};
    assign prod      = r_mag * r_dx;
    assign trial     = {r_rem, r_lo[DW-1]};
    assign ge        = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[wr_addr] <= i_x_value;
            mem_y[wr_addr] <= i_y_value;
        end
        if (rd_en) begin
            r_rx <= mem_x[rd_addr];
            r_ry <= mem_y[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (q_acc && (r_ptr < n1)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_more) begin
                    n_state = S_WALK;
                end else if (hit_eq) begin
                    n_state = S_HIT;
                end else if (interior) begin
                    n_state = S_LO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HIT:  n_state = S_IDLE;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = degen ? S_IDLE : S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = (r_cnt == DIV_LAST) ? S_FIN : S_DIV;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ptr      = r_ptr;
        n_j        = r_j;
        n_x        = r_x;
        n_last     = r_last;
        n_x1       = r_x1;
        n_x0       = r_x0;
        n_y0       = r_y0;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_dx       = r_dx;
        n_d        = r_d;
        n_rem      = r_rem;
        n_lo       = r_lo;
        n_cnt      = r_cnt;
        n_valid    = 1'b0;
        n_y_out    = r_y_out;
        n_in_range = r_in_range;
        rd_en      = 1'b0;
        rd_addr    = r_j;
        case (r_state)
            S_IDLE: begin
                if (q_acc) begin
                    n_x    = i_x_value;
                    n_last = i_last_of_run;
                    n_j    = r_ptr;
                    if (r_ptr < n1) begin
                        rd_en   = 1'b1;
                        rd_addr = r_ptr;
                    end else begin
                        n_valid    = 1'b1;
                        n_y_out    = '0;
                        n_in_range = 1'b0;
                        n_ptr      = i_last_of_run ? '0 : r_ptr;
                    end
                end
            end
            S_WALK: begin
                if (walk_more) begin
                    n_j     = r_j + AW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_j + AW'(1);
                end else begin
                    n_ptr = r_last ? '0 : r_j;
                    if (hit_eq) begin
                        rd_en   = 1'b1;
                        rd_addr = r_j;
                    end else if (interior) begin
                        n_x1    = r_rx;
                        rd_en   = 1'b1;
                        rd_addr = r_j - AW'(1);
                    end else begin
                        n_valid    = 1'b1;
                        n_y_out    = '0;
                        n_in_range = 1'b0;
                    end
                end
            end
            S_HIT: begin
                n_valid    = 1'b1;
                n_y_out    = r_ry;
                n_in_range = 1'b1;
            end
            S_LO: begin
                n_x0    = r_rx;
                n_y0    = r_ry;
                rd_en   = 1'b1;
                rd_addr = r_j;
            end
            S_HI: begin
                n_neg = dy[DW];
                n_mag = dy[DW] ? DW'(-dy) : dy[DW-1:0];
                n_dx  = r_x - r_x0;
                n_d   = r_x1 - r_x0;
                if (degen) begin
                    n_valid    = 1'b1;
                    n_y_out    = r_y0;
                    n_in_range = 1'b1;
                end
            end
            S_MUL: begin
                n_rem = prod[2*DW-1:DW];
                n_lo  = prod[DW-1:0];
                n_cnt = '0;
            end
            S_DIV: begin
                n_rem = ge ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
                n_lo  = {r_lo[DW-2:0], ge};
                n_cnt = r_cnt + 5'd1;
            end
            S_FIN: begin
                n_valid    = 1'b1;
                n_y_out    = r_neg ? (r_y0 - r_lo) : (r_y0 + r_lo);
                n_in_range = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_W'(2);
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_x        <= n_x;
        r_last     <= n_last;
        r_x1       <= n_x1;
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_dx       <= n_dx;
        r_d        <= n_d;
        r_rem      <= n_rem;
        r_lo       <= n_lo;
        r_cnt      <= n_cnt;
        r_y_out    <= n_y_out;
        r_in_range <= n_in_range;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_y_out    = r_y_out;
    assign o_in_range = r_in_range;

    `TLI_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `TLI_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, ld_acc, !o_valid)
    `TLI_ASSERT_NOW(a_div_rem_bound, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_d)

endmodule

### tb/interp_checker.sv
module interp_checker
    import tli_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             i_opcode,
    input  logic [9:0]       i_point_index,
    input  logic [DW-1:0]    i_x_value,
    input  logic [DW-1:0]    i_y_value,
    input  logic             i_last_of_run,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             o_valid,
    input  logic [DW-1:0]    o_y_out,
    input  logic             o_in_range,
    output int               o_results_due,
    output int               o_fail_count
);

    typedef struct packed {
        logic [DW-1:0] y;
        logic          in_range;
    } t_point_result;

    t_point_result        due_results_q[$];
    logic signed [DW-1:0] tab_x [DEPTH];
    logic signed [DW-1:0] tab_y [DEPTH];
    int                   walk_pos = 0;
    logic [CNT_W-1:0]     points_used = CNT_W'(2);
    int                   fails = 0;

    // y0 + (y1 - y0) * (x - x0) / (x1 - x0), quotient truncated toward zero
    function automatic logic [DW-1:0] lerp_y(input int lo, input int hi,
                                             input logic signed [DW-1:0] xq);
        longint          x0, x1, y0, y1, dy, xx, r;
        longint unsigned mag, dx, span, q;
        x0 = tab_x[lo];
        x1 = tab_x[hi];
        y0 = tab_y[lo];
        y1 = tab_y[hi];
        xx = xq;
        if (x1 <= x0 || xx <= x0) begin
            return y0[DW-1:0];
        end
        dy   = y1 - y0;
        mag  = (dy < 0) ? -dy : dy;
        dx   = xx - x0;
        span = x1 - x0;
        q    = (mag * dx) / span;
        r    = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
        return r[DW-1:0];
    endfunction

    function automatic t_point_result interp_query(input logic signed [DW-1:0] xq,
                                                   input logic lst);
        int            n, j;
        t_point_result r;
        n = (points_used < 2) ? 2 : int'(points_used);
        if (n > DEPTH) begin
            n = DEPTH;
        end
        j = walk_pos;
        r = '0;
        if (j < n - 1) begin
            while (j < n - 1 && xq > tab_x[j]) begin
                j++;
            end
            if (xq == tab_x[j]) begin
                r.y        = tab_y[j];
                r.in_range = 1'b1;
            end else if (j < n - 1 && j > 0) begin
                r.y        = lerp_y(j - 1, j, xq);
                r.in_range = 1'b1;
            end
        end
        walk_pos = lst ? 0 : j;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_point_result got, want, pred;
        if (!i_rst_n) begin
            walk_pos    = 0;
            points_used = CNT_W'(2);
        end else begin
            if (o_valid) begin
                got.y        = o_y_out;
                got.in_range = o_in_range;
                if (due_results_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected word: y_out %h in_range %b", got.y, got.in_range);
                    end
                end else begin
                    want = due_results_q.pop_front();
                    if (got.y !== want.y || got.in_range !== want.in_range) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: y_out %h (exp %h) in_range %b (exp %b)",
                                     got.y, want.y, got.in_range, want.in_range);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                points_used = i_cfg_wdata;
            end
            if (start && !busy) begin
                if (i_opcode == OP_LOAD) begin
                    if (i_point_index < DEPTH) begin
                        tab_x[i_point_index] = i_x_value;
                        tab_y[i_point_index] = i_y_value;
                    end
                end else begin
                    pred          = interp_query(i_x_value, i_last_of_run);
                    due_results_q = {due_results_q, pred};
                end
            end
        end
        o_results_due <= due_results_q.size();
        o_fail_count  <= fails;
    end

endmodule

### tb/tb.sv
module tb;
    import tli_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_WORDS = 1800;
    localparam int DIRECTED     = 21;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             start         = 1'b0;
    logic             i_opcode      = 1'b0;
    logic [9:0]       i_point_index = '0;
    logic [DW-1:0]    i_x_value     = '0;
    logic [DW-1:0]    i_y_value     = '0;
    logic             i_last_of_run = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata   = '0;
    logic             busy;
    logic             o_valid;
    logic [DW-1:0]    o_y_out;
    logic             o_in_range;

    int results_due;
    int fail_count;
    int cycle_cnt   = 0;
    int words_sent  = 0;
    int burst_left  = 1;

    logic signed [DW-1:0] tx [DEPTH];

    table_linear_interpolator_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_point_index(i_point_index),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_last_of_run(i_last_of_run),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_y_out      (o_y_out),
        .o_in_range   (o_in_range)
    );

    interp_checker #(
        .DEPTH(DEPTH)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_point_index(i_point_index),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_last_of_run(i_last_of_run),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_y_out      (o_y_out),
        .o_in_range   (o_in_range),
        .o_results_due(results_due),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic issue_word(input logic op, input logic [9:0] idx,
                              input logic [DW-1:0] xv, input logic [DW-1:0] yv,
                              input logic lst);
        int gap;
        start         <= 1'b1;
        i_opcode      <= op;
        i_point_index <= idx;
        i_x_value     <= xv;
        i_y_value     <= yv;
        i_last_of_run <= lst;
        do @(posedge i_clk); while (busy);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 4);
                2: gap = $urandom_range(1, 15);
                default: gap = $urandom_range(10, 45);
            endcase
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain(input int extra);
        start <= 1'b0;
        do @(posedge i_clk); while (results_due != 0 || busy);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ascending x with a randomly chosen spacing scale
    task automatic load_table(input int n);
        longint step_max, room, xv;
        logic [DW-1:0] yv;
        case ($urandom_range(0, 3))
            0: step_max = 3;
            1: step_max = 1000;
            2: step_max = 1 << 20;
            default: step_max = 64'd4294967295 / n;
        endcase
        if (step_max > 64'd4294967295 / n) begin
            step_max = 64'd4294967295 / n;
        end
        room = 64'd4294967295 - step_max * (n - 1);
        xv   = -64'sd2147483648 + longint'($urandom_range(0, 32'(room)));
        for (int k = 0; k < n; k++) begin
            tx[k] = xv[DW-1:0];
            yv    = $urandom_range(0, 1) ? $urandom : DW'($urandom_range(0, 2000) - 1000);
            issue_word(OP_LOAD, k[9:0], xv[DW-1:0], yv, 1'($urandom));
            xv += 1 + longint'($urandom_range(0, 32'(step_max - 1)));
        end
    endtask

    task automatic query_run(input int n, input int len);
        int     c, k;
        longint qv, span;
        logic   lst;
        c = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                k     = $urandom_range(0, n - 1);
                tx[k] = $urandom;
                issue_word(OP_LOAD, k[9:0], tx[k], $urandom, 1'($urandom));
            end
            if ($urandom_range(0, 99) < 8) begin
                qv = longint'(signed'(DW'($urandom)));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    c += $urandom_range(0, n / 4 + 1);
                end else if (i > 0) begin
                    c += $urandom_range(0, 2);
                end
                if (c > n) begin
                    c = n;
                end
                if (c == 0 && $urandom_range(0, 2) == 0) begin
                    qv = longint'(tx[0]) - longint'($urandom_range(1, 1 << 16));
                    if (qv < -64'sd2147483648) begin
                        qv = -64'sd2147483648;
                    end
                end else if (c >= n) begin
                    qv = longint'(tx[n - 1]) + longint'($urandom_range(0, 1 << 16));
                    if (qv > 64'sd2147483647) begin
                        qv = 64'sd2147483647;
                    end
                end else if (c == 0 || $urandom_range(0, 2) == 0) begin
                    qv = tx[c];
                end else begin
                    span = longint'(tx[c]) - longint'(tx[c - 1]);
                    if (span > 1) begin
                        qv = longint'(tx[c - 1]) + 1
                             + longint'($urandom_range(0, 32'(span - 2)));
                    end else begin
                        qv = tx[c];
                    end
                end
            end
            if (i == len - 1) begin
                lst = ($urandom_range(0, 9) != 0);
            end else begin
                lst = ($urandom_range(0, 49) == 0);
            end
            issue_word(OP_QUERY, 10'($urandom), qv[DW-1:0], $urandom, lst);
            if (lst) begin
                c = 0;
            end
        end
    endtask

    initial begin
        int p, n, cval, nq, len, r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain(4);
        set_count(11'd4);

        // extremes of x and y; exact hits, both slope signs, out of order
        // query, hit on the last point and a query after the walk has ended
        issue_word(OP_LOAD,  10'd0,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        issue_word(OP_LOAD,  10'd1,    32'h0000_0000, 32'h8000_0000, 1'b1);
        issue_word(OP_LOAD,  10'd2,    32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0);
        issue_word(OP_LOAD,  10'd3,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        issue_word(OP_LOAD,  10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        issue_word(OP_QUERY, 10'd1023, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'h0000_0001, 32'h0000_0000, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'h7FFF_FFFE, 32'h0000_0000, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'hFFFF_FFFB, 32'h0000_0000, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        issue_word(OP_QUERY, 10'd0,    32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        // below first point, then a reload that leaves the bracket non-ascending
        issue_word(OP_LOAD,  10'd0,    32'd100,       32'd10,        1'b0);
        issue_word(OP_LOAD,  10'd1,    32'd200,       32'd20,        1'b0);
        issue_word(OP_LOAD,  10'd2,    32'd300,       -32'sd30,      1'b0);
        issue_word(OP_LOAD,  10'd3,    32'd400,       32'd40,        1'b0);
        issue_word(OP_QUERY, 10'd0,    32'd50,        32'd0,         1'b0);
        issue_word(OP_QUERY, 10'd0,    32'd250,       32'd0,         1'b0);
        issue_word(OP_LOAD,  10'd1,    32'd350,       32'd20,        1'b0);
        issue_word(OP_QUERY, 10'd0,    32'd260,       32'd0,         1'b1);

        p = 0;
        while (words_sent < DIRECTED + RANDOM_WORDS) begin
            case (p)
                0: cval = 2047;
                1: cval = 1024;
                2: cval = 0;
                3: cval = 1;
                4: cval = 2;
                5: cval = 3;
                default: begin
                    r = $urandom_range(0, 19);
                    if (r < 15) begin
                        cval = $urandom_range(3, 24);
                    end else if (r < 18) begin
                        cval = $urandom_range(25, 200);
                    end else begin
                        cval = $urandom_range(1025, 2047);
                    end
                end
            endcase
            drain(4);
            set_count(CNT_W'(cval));
            n = (cval < 2) ? 2 : ((cval > DEPTH) ? DEPTH : cval);
            if (p == 0 || n < DEPTH) begin
                load_table(n);
            end
            nq = $urandom_range(20, 60);
            while (nq > 0) begin
                len = $urandom_range(1, 12);
                query_run(n, len);
                nq -= len;
            end
            p++;
        end

        drain(64);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tli_pkg.sv
design/table_linear_interpolator_core.sv
tb/interp_checker.sv
tb/tb.sv
